>>> rtl/ppdm_pkg.sv
`default_nettype none

package ppdm_pkg;

	// Fixed field widths of the result and configuration.
	localparam int RATE_W = 27;
	localparam int DUTY_W = 10;

	// Scale for the duty ratio and the tick rate after reset.
	localparam logic [DUTY_W-1:0] DUTY_SCALE = 10'd1000;
	localparam logic [RATE_W-1:0] RATE_RESET = 27'd1000000;

	// Depth of the queue between the edge classifier and the arithmetic.
	localparam int JOB_DEPTH = 2;

	// Status of one iterative divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Back-end sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} back_state_t;

endpackage

`default_nettype wire

>>> rtl/ppdm_front.sv
`default_nettype none

module ppdm_front import ppdm_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	input  wire logic                     full,
	input  wire logic                     edge_is_falling,
	input  wire logic [COUNT_WIDTH-1:0]   edge_ticks,
	output logic                          job_push,
	output logic [2*COUNT_WIDTH-1:0]      job_data
);

	logic                   armed_falling_q;
	logic                   have_low_q;
	logic [COUNT_WIDTH-1:0] low_q;
	logic                   accept;
	logic                   match;

	// An edge counts only when it is taken and matches the armed polarity.
	assign accept = push && !full;
	assign match  = accept && (edge_is_falling == armed_falling_q);

	// A falling edge with a low time held completes one measurement.
	assign job_push = match && edge_is_falling && have_low_q;
	assign job_data = {low_q, edge_ticks};

	// Polarity tracking and low phase storage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_falling_q <= 1'b1;
			have_low_q      <= 1'b0;
			low_q           <= '0;
		end else if (match) begin
			if (!edge_is_falling) begin
				low_q           <= edge_ticks;
				have_low_q      <= 1'b1;
				armed_falling_q <= 1'b1;
			end else if (!have_low_q) begin
				armed_falling_q <= 1'b0;
			end else begin
				have_low_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/ppdm_fifo.sv
`default_nettype none

module ppdm_fifo import ppdm_pkg::*; #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  full,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

>>> rtl/ppdm_div.sv
`default_nettype none

module ppdm_div import ppdm_pkg::*; #(
	parameter int NW  = 27,
	parameter int DVW = 17
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [NW-1:0]  dividend,
	input  wire logic [DVW-1:0] divisor,
	output div_stat_t           stat,
	output logic [NW-1:0]       quotient
);

	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   quo_q;
	logic [DVW-1:0]  rem_q;
	logic [DVW-1:0]  dvs_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DVW:0]    rem_sh;
	logic [DVW+1:0]  diff;
	logic            ge;

	// One restoring step: bring down the next dividend bit and try a subtract.
	assign rem_sh = {rem_q, quo_q[NW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign ge     = !diff[DVW+1];

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DVW-1:0] : rem_sh[DVW-1:0];
		end
	end

endmodule

`default_nettype wire

>>> rtl/ppdm_back.sv
`default_nettype none

module ppdm_back import ppdm_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   job_empty,
	input  wire logic [2*COUNT_WIDTH-1:0] job_data,
	output logic                        job_pop,
	input  wire logic [RATE_W-1:0]      tick_rate,
	input  wire logic                   pop,
	output logic                        empty,
	output logic [COUNT_WIDTH-1:0]      low_ticks,
	output logic [COUNT_WIDTH-1:0]      high_ticks,
	output logic [RATE_W-1:0]           freq_hz,
	output logic [DUTY_W-1:0]           duty_permille,
	output logic                        zero_period
);

	localparam int PW = COUNT_WIDTH + 1;
	localparam int MW = COUNT_WIDTH + DUTY_W;
	localparam int DW = (MW > RATE_W) ? MW : RATE_W;

	back_state_t             state_q;
	logic [COUNT_WIDTH-1:0]  low_q;
	logic [COUNT_WIDTH-1:0]  high_q;
	logic [PW-1:0]           period_q;
	logic [MW-1:0]           prod_q;
	logic                    start_q;
	logic [RATE_W-1:0]       freq_res_q;
	logic [DUTY_W-1:0]       duty_res_q;
	logic                    zero_q;
	logic                    out_valid_q;
	logic                    out_load;
	div_stat_t               freq_stat;
	div_stat_t               duty_stat;
	logic [DW-1:0]           freq_quo;
	logic [DW-1:0]           duty_quo;

	assign job_pop  = (state_q == ST_IDLE) && !job_empty;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || pop);
	assign empty    = !out_valid_q;

	// Frequency and duty quotients run side by side over the same divisor.
	ppdm_div #(.NW(DW), .DVW(PW)) u_div_freq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (DW'(tick_rate)),
		.divisor  (period_q),
		.stat     (freq_stat),
		.quotient (freq_quo)
	);

	ppdm_div #(.NW(DW), .DVW(PW)) u_div_duty (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (DW'(prod_q)),
		.divisor  (period_q),
		.stat     (duty_stat),
		.quotient (duty_quo)
	);

	// Sequencer: take a job, scale, divide, hand over to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					start_q <= 1'b1;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (freq_stat.done && !duty_stat.busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the job in flight.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			low_q  <= job_data[2*COUNT_WIDTH-1:COUNT_WIDTH];
			high_q <= job_data[COUNT_WIDTH-1:0];
		end
		if (state_q == ST_MUL) begin
			period_q <= {1'b0, low_q} + {1'b0, high_q};
			prod_q   <= {{DUTY_W{1'b0}}, high_q} * {{COUNT_WIDTH{1'b0}}, DUTY_SCALE};
		end
		if (state_q == ST_DIV && freq_stat.done) begin
			zero_q     <= (period_q == '0);
			freq_res_q <= (period_q == '0) ? '0 : freq_quo[RATE_W-1:0];
			duty_res_q <= (period_q == '0) ? '0 : duty_quo[DUTY_W-1:0];
		end
		if (out_load) begin
			low_ticks     <= low_q;
			high_ticks    <= high_q;
			freq_hz       <= freq_res_q;
			duty_permille <= duty_res_q;
			zero_period   <= zero_q;
		end
	end

endmodule

`default_nettype wire

>>> rtl/pulse_period_duty_meter.sv
// Pulse period and duty meter.
// Input channel: each beat is one captured edge (edge_is_falling, edge_ticks), taken
// on a clock edge with push high and full low. Edges against the armed polarity are
// dropped; a rising edge records the low phase, and a falling edge after it closes a
// measurement, which is queued for the arithmetic back end.
// Result channel: while empty is low the oldest measurement (low_ticks, high_ticks,
// freq_hz, duty_permille, zero_period) is on the ports; pop with empty low takes it.
// Configuration: cfg_valid/cfg_ready write tick_rate_hz; cfg_ready is always high.
// Two restoring dividers with DW = max(27, COUNT_WIDTH + 10) bit dividends, one quotient
// bit per cycle, work out the results; the back end takes a new queued measurement only
// after the last one is handed to the result register. Edges that close no measurement
// add nothing to the job queue.
// A two-entry job queue and a result register decouple the sides: edges keep being
// taken while a result waits, and full rises when both queued jobs wait behind the
// dividers or a stalled receiver; every edge then waits. Reset clears the queues, arms
// for a falling edge with no low time held, and sets tick_rate_hz to 1000000.
`default_nettype none

module pulse_period_duty_meter import ppdm_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic                   edge_is_falling,
	input  wire logic [COUNT_WIDTH-1:0] edge_ticks,
	output logic                        empty,
	input  wire logic                   pop,
	output logic [COUNT_WIDTH-1:0]      low_ticks,
	output logic [COUNT_WIDTH-1:0]      high_ticks,
	output logic [RATE_W-1:0]           freq_hz,
	output logic [DUTY_W-1:0]           duty_permille,
	output logic                        zero_period,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [RATE_W-1:0]      cfg_data
);

	logic [RATE_W-1:0]        tick_rate_q;
	logic                     job_push;
	logic [2*COUNT_WIDTH-1:0] job_wdata;
	logic [2*COUNT_WIDTH-1:0] job_rdata;
	logic                     job_pop;
	logic                     job_empty;

	assign cfg_ready = 1'b1;

	// Tick rate register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tick_rate_q <= cfg_data;
		end
	end

	// Edge classification and phase tracking.
	ppdm_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.edge_is_falling (edge_is_falling),
		.edge_ticks      (edge_ticks),
		.job_push        (job_push),
		.job_data        (job_wdata)
	);

	// Queue of finished phase pairs.
	ppdm_fifo #(.WIDTH(2*COUNT_WIDTH), .DEPTH(JOB_DEPTH)) u_jobs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_wdata),
		.rd_en   (job_pop),
		.rd_data (job_rdata),
		.full    (full),
		.empty   (job_empty)
	);

	// Frequency and duty arithmetic with the result register.
	ppdm_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_empty     (job_empty),
		.job_data      (job_rdata),
		.job_pop       (job_pop),
		.tick_rate     (tick_rate_q),
		.pop           (pop),
		.empty         (empty),
		.low_ticks     (low_ticks),
		.high_ticks    (high_ticks),
		.freq_hz       (freq_hz),
		.duty_permille (duty_permille),
		.zero_period   (zero_period)
	);

endmodule

`default_nettype wire

>>> rtl/ppdm_checker.sv
`default_nettype none

module ppdm_checker import ppdm_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   empty,
	input wire logic                   pop,
	input wire logic [COUNT_WIDTH-1:0] low_ticks,
	input wire logic [COUNT_WIDTH-1:0] high_ticks,
	input wire logic [RATE_W-1:0]      freq_hz,
	input wire logic [DUTY_W-1:0]      duty_permille,
	input wire logic                   zero_period
);

	// A zero period reports zero frequency and duty.
	a_zero_results: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && zero_period) |-> (freq_hz == '0 && duty_permille == '0))
		else $error("zero period with nonzero results");

	// The zero flag agrees with the reported phases.
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (zero_period == (low_ticks == '0 && high_ticks == '0)))
		else $error("zero_period disagrees with phase lengths");

	// Duty never exceeds the full scale.
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (duty_permille <= DUTY_SCALE))
		else $error("duty beyond full scale");

	// A waiting result holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(low_ticks) && $stable(high_ticks)
			&& $stable(freq_hz) && $stable(duty_permille)))
		else $error("result changed while waiting");

endmodule

bind pulse_period_duty_meter ppdm_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_ppdm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.pop           (pop),
	.low_ticks     (low_ticks),
	.high_ticks    (high_ticks),
	.freq_hz       (freq_hz),
	.duty_permille (duty_permille),
	.zero_period   (zero_period)
);

`default_nettype wire

>>> test/tb_pulse_period_duty_meter.sv
`timescale 1ns / 1ps

module tb_pulse_period_duty_meter;
	import ppdm_pkg::*;

	localparam int CW = 16;
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEMS_PER_PHASE = 246;
	localparam int NUM_PHASES = 6;

	// Edge directions as they appear on edge_is_falling.
	localparam logic RISE = 1'b0;
	localparam logic FALL = 1'b1;

	// Idle and stall odds, in percent, for each phase; phase 0 is the directed part.
	localparam int SEND_IDLE[NUM_PHASES]  = '{0, 0, 83, 0, 37, 0};
	localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 0, 83, 37, 0};

	typedef struct packed {
		logic          falling;
		logic [CW-1:0] ticks;
	} edge_t;

	typedef struct packed {
		logic [CW-1:0]     low;
		logic [CW-1:0]     high;
		logic [RATE_W-1:0] freq;
		logic [DUTY_W-1:0] duty;
		logic              zero;
	} meas_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic              edge_is_falling = 1'b0;
	logic [CW-1:0]     edge_ticks = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [CW-1:0]     low_ticks;
	logic [CW-1:0]     high_ticks;
	logic [RATE_W-1:0] freq_hz;
	logic [DUTY_W-1:0] duty_permille;
	logic              zero_period;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [RATE_W-1:0] cfg_data = '0;

	pulse_period_duty_meter #(.COUNT_WIDTH(CW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.edge_is_falling(edge_is_falling),
		.edge_ticks(edge_ticks),
		.empty(empty),
		.pop(pop),
		.low_ticks(low_ticks),
		.high_ticks(high_ticks),
		.freq_hz(freq_hz),
		.duty_permille(duty_permille),
		.zero_period(zero_period),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Edges waiting to be driven and measurements waiting to come out.
	edge_t edge_queue[$];
	meas_t meas_queue[$];

	// Predicted meter state and the tick rate it was last given.
	logic              arm_fall;
	logic              low_held;
	logic [CW-1:0]     low_len;
	logic [RATE_W-1:0] rate_hz;

	// Shadow of the meter state used only to shape the stimulus.
	logic gen_arm_fall = 1'b1;
	logic gen_low_held = 1'b0;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          queued_total = 0;
	int          accepted_total = 0;
	int          mismatch_count = 0;
	int unsigned cycle_count = 0;

	initial forever #4 clk = ~clk;

	// Apply one accepted edge to the predicted state and queue any measurement it closes.
	function automatic void measure_edge(edge_t e);
		logic [CW:0] period;
		logic [31:0] scaled;
		meas_t m;
		if (e.falling != arm_fall)
			return;
		if (!e.falling) begin
			low_len = e.ticks;
			low_held = 1'b1;
			arm_fall = 1'b1;
		end else if (!low_held) begin
			arm_fall = 1'b0;
		end else begin
			low_held = 1'b0;
			period = {1'b0, low_len} + {1'b0, e.ticks};
			m.low = low_len;
			m.high = e.ticks;
			m.zero = (period == '0);
			m.freq = '0;
			m.duty = '0;
			if (period != '0) begin
				m.freq = rate_hz / RATE_W'(period);
				scaled = 32'(e.ticks) * 32'(DUTY_SCALE);
				m.duty = DUTY_W'(scaled / 32'(period));
			end
			meas_queue.push_back(m);
		end
	endfunction

	// Queue one edge and track which direction the meter will accept next.
	function automatic void add_edge(logic falling, logic [CW-1:0] ticks);
		edge_t e;
		e.falling = falling;
		e.ticks = ticks;
		if (falling == gen_arm_fall) begin
			if (!falling) begin
				gen_low_held = 1'b1;
				gen_arm_fall = 1'b1;
			end else if (!gen_low_held) begin
				gen_arm_fall = 1'b0;
			end else begin
				gen_low_held = 1'b0;
			end
		end
		edge_queue.push_back(e);
		queued_total++;
	endfunction

	// Tick counts lean toward small values, the ends of the range and its midpoint.
	function automatic logic [CW-1:0] pick_ticks();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 30)
			return CW'($urandom_range(15));
		if (r < 38)
			return '0;
		if (r < 46)
			return '1;
		if (r < 52)
			return CW'(16'h8000 + $urandom_range(3) - 2);
		return CW'($urandom);
	endfunction

	// Mostly well-formed edge sequences, with some edges of the wrong direction mixed in.
	// Only edges the meter will act on count toward n.
	task automatic queue_random(int n);
		int   counted;
		logic dir;
		counted = 0;
		while (counted < n) begin
			if ($urandom_range(99) < 85)
				dir = gen_arm_fall;
			else
				dir = 1'($urandom_range(1));
			if (dir == gen_arm_fall)
				counted++;
			add_edge(dir, pick_ticks());
		end
	endtask

	// Wait until every queued edge is taken and every measurement is checked.
	task automatic drain();
		while (accepted_total != queued_total || meas_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the tick rate while the meter is idle.
	task automatic write_rate(logic [RATE_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		rate_hz = value;
	endtask

	// Edge driver: offers the next pending edge, unless an idle is drawn, whenever the previous beat is gone.
	always @(posedge clk) begin
		edge_t nxt;
		if (push && !full) begin
			measure_edge(edge_t'({edge_is_falling, edge_ticks}));
			accepted_total++;
		end
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || !full) begin
			if (edge_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = edge_queue.pop_front();
				push <= 1'b1;
				edge_is_falling <= nxt.falling;
				edge_ticks <= nxt.ticks;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Result monitor: checks each popped measurement against the oldest prediction.
	always @(posedge clk) begin
		meas_t want;
		if (pop && !empty) begin
			if (meas_queue.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: low %0d high %0d freq %0d duty %0d zero %0d",
						low_ticks, high_ticks, freq_hz, duty_permille, zero_period);
			end else begin
				want = meas_queue.pop_front();
				if (low_ticks !== want.low || high_ticks !== want.high ||
						freq_hz !== want.freq || duty_permille !== want.duty ||
						zero_period !== want.zero) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch: expected low %0d high %0d freq %0d duty %0d zero %0d",
							want.low, want.high, want.freq, want.duty, want.zero);
						$display("          got      low %0d high %0d freq %0d duty %0d zero %0d",
							low_ticks, high_ticks, freq_hz, duty_permille, zero_period);
					end
				end
			end
		end
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL pulse_period_duty_meter");
			$finish;
		end
	end

	initial begin
		logic [RATE_W-1:0] next_rate;

		arm_fall = 1'b1;
		low_held = 1'b0;
		low_len = '0;
		rate_hz = RATE_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the tick rate left by reset.
		add_edge(RISE, 16'd5);       // rising edge while armed for falling is dropped
		add_edge(FALL, 16'd7);       // falling edge with no low time re-arms for rising
		add_edge(FALL, 16'd9);       // dropped
		add_edge(RISE, 16'd0);
		add_edge(RISE, 16'd3);       // dropped
		add_edge(FALL, 16'd0);       // zero period
		add_edge(FALL, 16'd100);
		add_edge(RISE, 16'hFFFF);
		add_edge(FALL, 16'hFFFF);    // longest period
		add_edge(FALL, 16'd1);
		add_edge(RISE, 16'd1);
		add_edge(FALL, 16'd0);       // no high time, duty of zero
		add_edge(FALL, 16'd1);
		add_edge(RISE, 16'd0);
		add_edge(FALL, 16'hFFFF);    // no low time, full duty
		add_edge(FALL, 16'd0);
		add_edge(RISE, 16'd1);
		add_edge(FALL, 16'd1);       // equal low and high time, half duty
		add_edge(FALL, 16'd0);
		add_edge(RISE, 16'd12345);
		add_edge(FALL, 16'd54321);
		drain();

		// Random phases, each with its own tick rate and handshake pressure.
		for (int p = 1; p < NUM_PHASES; p++) begin
			case (p)
				1: next_rate = 27'd100000000;
				2: next_rate = 27'd1;
				3: next_rate = RATE_W'($urandom_range(100000000, 1));
				4: next_rate = '1;
				default: next_rate = '0;
			endcase
			write_rate(next_rate);
			send_idle_pct = SEND_IDLE[p];
			recv_stall_pct = RECV_STALL[p];
			queue_random(ITEMS_PER_PHASE);
			drain();
		end

		if (mismatch_count == 0 && meas_queue.size() == 0)
			$display("PASS pulse_period_duty_meter");
		else
			$display("FAIL pulse_period_duty_meter");
		$finish;
	end

endmodule
